// ----- rtl/wms_pkg.sv -----
`default_nettype none

package wms_pkg;

    // event kinds
    localparam logic [1:0] ACT_VALID        = 2'd0;
    localparam logic [1:0] ACT_MALFORMED    = 2'd1;
    localparam logic [1:0] ACT_LINK_TIMEOUT = 2'd2;

    // register indexes (byte address / 4)
    localparam logic [1:0] REG_CHARGE_THR  = 2'd0;
    localparam logic [1:0] REG_MOTOR_THR   = 2'd1;
    localparam logic [1:0] REG_STOP_TMO    = 2'd2;

    // register reset values
    localparam logic [9:0]  CHARGE_THR_RST = 10'd270;
    localparam logic [6:0]  MOTOR_THR_RST  = 7'd12;
    localparam logic [31:0] STOP_TMO_RST   = 32'd60000;

    typedef enum logic [2:0] {
        ST_HOME  = 3'd0,
        ST_FWD   = 3'd1,
        ST_BWD   = 3'd2,
        ST_STOP  = 3'd3,
        ST_ALARM = 3'd4,
        ST_LINK  = 3'd5
    } t_status;

    typedef struct packed {
        logic [1:0]        action;
        logic [9:0]        battery_decivolts;
        logic signed [7:0] motor_volts;
        logic [31:0]       now_ms;
        logic [31:0]       epoch_seconds;
    } t_in_req;

    typedef struct packed {
        logic [2:0]  reported_status;
        logic        status_changed;
        logic [31:0] trip_start_seconds;
    } t_out_req;

endpackage

`default_nettype wire

// ----- rtl/wagon_motion_status_fsm_top.sv -----
// Wagon motion status tracker. Each telemetry request carries an event kind,
// battery level in tenths of a volt, a signed motor voltage, a wrapping
// millisecond time and a wall-clock time in seconds; each produces exactly
// one result request with the reported status (home, forward, backward,
// stopped, alarm or link error), a flag set when that status differs from
// the one reported before, and the wall-clock time at which the last trip
// left home. A request goes through two registers: an input register and a
// result register, with the state machine update in between. The result is
// offered from the result register, which loads when it is free, and a new
// request is accepted every cycle as long as the result side takes its
// results. The three thresholds sit on an APB-style port at byte addresses
// 0, 4 and 8; the user must write them only while no request is in flight,
// which the block itself does not enforce.
`default_nettype none

module wagon_motion_status_fsm_top (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    // input channel
    input  wire                    i_in_valid,
    output logic                   o_in_stall,
    input  wire wms_pkg::t_in_req  i_in_req,
    // result channel
    output logic                   o_out_valid,
    input  wire                    i_out_stall,
    output wms_pkg::t_out_req      o_out_req,
    // configuration port
    input  wire                    psel,
    input  wire                    penable,
    input  wire                    pwrite,
    input  wire  [3:0]             paddr,
    input  wire  [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);
    import wms_pkg::*;

    // configuration registers
    logic [9:0]  r_charge_thr;
    logic [6:0]  r_motor_thr;
    logic [31:0] r_stop_tmo;

    // block state
    t_status     r_wagon_state, n_wagon_state;
    t_status     r_last_reported;
    logic [31:0] r_stop_started;
    logic [31:0] r_trip_started;

    // pipeline registers
    logic        r_in_valid;
    t_in_req     r_in;
    logic        r_out_valid;
    t_out_req    r_out;

    logic        out_load;
    logic        proc;
    logic        in_accept;
    logic        cfg_wr;
    logic [1:0]  cfg_idx;

    // decoded event
    logic        is_link;
    logic [9:0]  battery;
    logic signed [8:0] motor;
    logic signed [8:0] thr_pos;
    logic signed [8:0] thr_neg;
    logic        chg;
    logic        mv;
    t_status     mv_dir;
    logic        tmo_hit;
    logic [31:0] stop_elapsed;

    // outputs of the state machine
    t_status     status;
    logic        latch_stop;
    logic        latch_trip;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_charge_thr <= CHARGE_THR_RST;
            r_motor_thr  <= MOTOR_THR_RST;
            r_stop_tmo   <= STOP_TMO_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_CHARGE_THR: r_charge_thr <= pwdata[9:0];
                REG_MOTOR_THR:  r_motor_thr  <= pwdata[6:0];
                REG_STOP_TMO:   r_stop_tmo   <= pwdata;
                default: begin
                    // address beyond the register list: write dropped
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_CHARGE_THR: prdata = {22'd0, r_charge_thr};
            REG_MOTOR_THR:  prdata = {25'd0, r_motor_thr};
            REG_STOP_TMO:   prdata = r_stop_tmo;
            default:        prdata = 32'd0;
        endcase
    end

    // ---------------- handshake ----------------
    // the result register frees up when empty or when its result is taken
    assign out_load   = !r_out_valid || !i_out_stall;
    assign proc       = r_in_valid && out_load;
    assign o_in_stall = r_in_valid && !out_load;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_in_req;
        end
    end

    // ---------------- event decode ----------------
    // link timeout and the unused code both report link error
    assign is_link = (r_in.action != ACT_VALID) && (r_in.action != ACT_MALFORMED);

    // malformed message reads as zero battery and zero motor
    always_comb begin
        if (r_in.action == ACT_MALFORMED) begin
            battery = 10'd0;
            motor   = 9'sd0;
        end else begin
            battery = r_in.battery_decivolts;
            motor   = 9'(r_in.motor_volts);
        end
    end

    assign thr_pos = $signed({2'b00, r_motor_thr});
    assign thr_neg = -thr_pos;
    assign chg     = battery >= r_charge_thr;

    // forward wins when the threshold is zero and the motor is zero
    always_comb begin
        if (motor >= thr_pos) begin
            mv     = 1'b1;
            mv_dir = ST_FWD;
        end else if (motor <= thr_neg) begin
            mv     = 1'b1;
            mv_dir = ST_BWD;
        end else begin
            mv     = 1'b0;
            mv_dir = ST_HOME;
        end
    end

    // wrapping millisecond difference since the stop began
    assign stop_elapsed = r_in.now_ms - r_stop_started;
    assign tmo_hit      = stop_elapsed > r_stop_tmo;

    // ---------------- state machine: next state ----------------
    always_comb begin
        n_wagon_state = r_wagon_state;
        case (r_wagon_state)
            ST_HOME: begin
                if (!mv && !chg)     n_wagon_state = ST_STOP;
                else if (mv && !chg) n_wagon_state = mv_dir;
            end
            ST_FWD, ST_BWD: begin
                if (!mv && !chg)     n_wagon_state = ST_STOP;
                else if (!mv && chg) n_wagon_state = ST_HOME;
            end
            ST_STOP: begin
                if (!mv && chg)      n_wagon_state = ST_HOME;
                else if (mv && !chg) n_wagon_state = mv_dir;
                else if (tmo_hit)    n_wagon_state = ST_ALARM;
            end
            ST_ALARM: begin
                if (!mv && chg)      n_wagon_state = ST_HOME;
                else if (mv && !chg) n_wagon_state = mv_dir;
            end
            default: n_wagon_state = ST_HOME;
        endcase
    end

    // ---------------- state machine: outputs ----------------
    always_comb begin
        latch_stop = 1'b0;
        latch_trip = 1'b0;
        case (r_wagon_state)
            ST_HOME: begin
                latch_stop = !mv && !chg;
                latch_trip = mv && !chg;
            end
            ST_FWD, ST_BWD: begin
                latch_stop = !mv && !chg;
            end
            default: begin
                // stopped and alarm never latch; a new trip starts only from home
            end
        endcase
        status = is_link ? ST_LINK : n_wagon_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wagon_state   <= ST_HOME;
            r_last_reported <= ST_HOME;
            r_stop_started  <= 32'd0;
            r_trip_started  <= 32'd0;
        end else if (proc) begin
            r_last_reported <= status;
            if (!is_link) begin
                r_wagon_state <= n_wagon_state;
                if (latch_stop) r_stop_started <= r_in.now_ms;
                if (latch_trip) r_trip_started <= r_in.epoch_seconds;
            end
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc) begin
            r_out.reported_status    <= status;
            r_out.status_changed     <= status != r_last_reported;
            r_out.trip_start_seconds <= (!is_link && latch_trip) ? r_in.epoch_seconds
                                                                  : r_trip_started;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

    // ---------------- assertions ----------------
    // a link error request leaves the machine and its latches alone
    a_link_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && is_link) |=> ($stable(r_wagon_state) && $stable(r_stop_started)
                               && $stable(r_trip_started)))
        else $error("link error request changed the wagon state");

    // the remembered status is the one just put into the result register
    a_last_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc |=> (r_last_reported == t_status'(r_out.reported_status)))
        else $error("last reported status differs from the delivered one");

    // trip start moves only when the wagon leaves home
    a_trip_from_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(r_trip_started)) |->
            ($past(r_wagon_state) == ST_HOME)
            && (r_wagon_state == ST_FWD || r_wagon_state == ST_BWD))
        else $error("trip start latched outside a departure from home");

    // stop time moves only on entering stopped
    a_stop_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(r_stop_started)) |-> (r_wagon_state == ST_STOP))
        else $error("stop time latched without entering stopped");

endmodule

`default_nettype wire

// ----- sim/wms_status_check.sv -----
`timescale 1ns / 100ps

module wms_status_check (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    input  wire                    i_in_stall,
    input  wms_pkg::t_in_req       i_in_req,
    input  wire                    i_out_valid,
    input  wire                    i_out_stall,
    input  wms_pkg::t_out_req      i_out_req,
    input  wire                    psel,
    input  wire                    penable,
    input  wire                    pwrite,
    input  wire  [3:0]             paddr,
    input  wire  [31:0]            pwdata,
    input  wire                    pready,
    output int                     o_pending,
    output int                     o_errors
);

    import wms_pkg::*;

    // shadow copy of the thresholds
    logic [9:0]  chg_thr;
    logic [6:0]  mot_thr;
    logic [31:0] stop_tmo;

    // shadow copy of the wagon machine
    t_status     wagon_st;
    t_status     last_st;
    logic [31:0] stop_ms;
    logic [31:0] trip_s;

    t_out_req    status_due[$];
    int          err_cnt = 0;

    function automatic t_out_req next_wagon_status(input t_in_req ev);
        t_out_req    res;
        t_status     st;
        t_status     dir;
        logic [9:0]  batt;
        logic [31:0] elapsed;
        logic        chg;
        logic        moving;
        int          motor;
        int          thr;
        thr = int'(mot_thr);
        if (ev.action >= ACT_LINK_TIMEOUT) begin
            // link timeout, state and latches held
            st = ST_LINK;
        end else begin
            batt  = ev.battery_decivolts;
            motor = int'($signed(ev.motor_volts));
            if (ev.action == ACT_MALFORMED) begin
                batt  = '0;
                motor = 0;
            end
            chg    = (batt >= chg_thr);
            moving = 1'b1;
            if (motor >= thr) begin
                dir = ST_FWD;
            end else if (motor <= -thr) begin
                dir = ST_BWD;
            end else begin
                dir    = ST_HOME;
                moving = 1'b0;
            end
            elapsed = ev.now_ms - stop_ms;
            case (wagon_st)
                ST_HOME: begin
                    if (!moving && !chg) begin
                        wagon_st = ST_STOP;
                        stop_ms  = ev.now_ms;
                    end else if (moving && !chg) begin
                        trip_s   = ev.epoch_seconds;
                        wagon_st = dir;
                    end
                end
                ST_FWD, ST_BWD: begin
                    if (!moving && !chg) begin
                        wagon_st = ST_STOP;
                        stop_ms  = ev.now_ms;
                    end else if (!moving && chg) begin
                        wagon_st = ST_HOME;
                    end
                end
                ST_STOP: begin
                    if (!moving && chg)
                        wagon_st = ST_HOME;
                    else if (moving && !chg)
                        wagon_st = dir;
                    else if (elapsed > stop_tmo)
                        wagon_st = ST_ALARM;
                end
                ST_ALARM: begin
                    if (!moving && chg)
                        wagon_st = ST_HOME;
                    else if (moving && !chg)
                        wagon_st = dir;
                end
                default: wagon_st = ST_HOME;
            endcase
            st = wagon_st;
        end
        res.reported_status    = st;
        res.status_changed     = (st != last_st);
        res.trip_start_seconds = trip_s;
        last_st = st;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out_req want;
        if (!i_rst_n) begin
            chg_thr  = CHARGE_THR_RST;
            mot_thr  = MOTOR_THR_RST;
            stop_tmo = STOP_TMO_RST;
            wagon_st = ST_HOME;
            last_st  = ST_HOME;
            stop_ms  = '0;
            trip_s   = '0;
            status_due.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_CHARGE_THR: chg_thr  = pwdata[9:0];
                    REG_MOTOR_THR:  mot_thr  = pwdata[6:0];
                    REG_STOP_TMO:   stop_tmo = pwdata;
                    default: ;
                endcase
            end
            // results first: a request never comes out in its own cycle
            if (i_out_valid && !i_out_stall) begin
                if (status_due.size() == 0) begin
                    $error("result request with nothing expected, reported_status %0d",
                           i_out_req.reported_status);
                    err_cnt++;
                end else begin
                    want = status_due.pop_front();
                    if (i_out_req.reported_status !== want.reported_status) begin
                        $error("reported_status: expected %0d, actual %0d",
                               want.reported_status, i_out_req.reported_status);
                        err_cnt++;
                    end
                    if (i_out_req.status_changed !== want.status_changed) begin
                        $error("status_changed: expected %0d, actual %0d",
                               want.status_changed, i_out_req.status_changed);
                        err_cnt++;
                    end
                    if (i_out_req.trip_start_seconds !== want.trip_start_seconds) begin
                        $error("trip_start_seconds: expected %0d, actual %0d",
                               want.trip_start_seconds, i_out_req.trip_start_seconds);
                        err_cnt++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                status_due.push_back(next_wagon_status(i_in_req));
        end
        o_pending <= status_due.size();
        o_errors  <= err_cnt;
    end

endmodule

// ----- sim/wagon_motion_status_fsm_top_tb.sv -----
`timescale 1ns / 100ps

module wagon_motion_status_fsm_top_tb;

    import wms_pkg::*;

    // action 3 is outside the defined kinds and must act as a link timeout
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    // cycles without any handshake before the run is declared hung
    localparam int WATCHDOG_LIMIT = 2000;

    logic        clk = 1'b0;
    logic        rst_n;

    // request channel into the block
    logic        in_valid;
    logic        in_stall;
    t_in_req     in_req;

    // result channel out of the block
    logic        out_valid;
    logic        out_stall;
    t_out_req    out_req;

    // apb-style threshold port
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          pending;
    int          errors;
    int          idle_cycles = 0;

    // idling control shared by both sides; cleared for the last part of the run
    bit          idle_on;
    int          gap_pct;
    int          sent_cnt;
    logic [31:0] ms_now;

    always #10 clk = ~clk;

    wagon_motion_status_fsm_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_req   (out_req),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // the checker watches all three ports, keeps its own wagon machine and
    // compares every result request with the oldest expectation
    wms_status_check status_chk (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_req    (in_req),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_req   (out_req),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .o_pending   (pending),
        .o_errors    (errors)
    );

    // idling density changes now and then, zero gives a stretch with no gaps
    function automatic int pick_idle_pct();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 10;
            default: return 35;
        endcase
    endfunction

    // apb write: setup, then access until pready
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // present one request, maybe after a gap, and hold it until taken;
    // entered and left right after a rising edge
    task automatic send_event(input t_in_req ev);
        if (sent_cnt % 40 == 0)
            gap_pct = pick_idle_pct();
        sent_cnt++;
        if (idle_on && $urandom_range(0, 99) < gap_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= ev;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic send_fields(input logic [1:0] act, input int batt, input int motor,
                               input logic [31:0] now, input logic [31:0] epoch);
        t_in_req ev;
        ev.action            = act;
        ev.battery_decivolts = batt[9:0];
        ev.motor_volts       = motor[7:0];
        ev.now_ms            = now;
        ev.epoch_seconds     = epoch;
        send_event(ev);
    endtask

    // drop valid and let every expected result come back before touching
    // the thresholds; every request yields a result, so a short pause will do
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    // one setting of the thresholds followed by random telemetry; upper
    // register bits get junk that the block must drop
    task automatic run_phase(input int count, input logic [9:0] chg,
                             input logic [6:0] mthr, input logic [31:0] tmo);
        t_in_req     ev;
        int          chg_i;
        int          thr_i;
        int          mv;
        int          pick;
        logic [31:0] delta;
        chg_i = int'(chg);
        thr_i = int'(mthr);
        write_reg(REG_CHARGE_THR, ($urandom() & ~32'h3FF) | {22'd0, chg});
        write_reg(REG_MOTOR_THR, ($urandom() & ~32'h7F) | {25'd0, mthr});
        write_reg(REG_STOP_TMO, tmo);
        ms_now = $urandom();
        for (int i = 0; i < count; i++) begin
            // mostly real readings, some malformed, some link drops
            pick = $urandom_range(0, 19);
            if (pick < 15)
                ev.action = ACT_VALID;
            else if (pick < 17)
                ev.action = ACT_MALFORMED;
            else if (pick < 19)
                ev.action = ACT_LINK_TIMEOUT;
            else
                ev.action = ACT_UNUSED;

            // battery biased to either side of the charge threshold
            pick = $urandom_range(0, 9);
            if (pick < 4)
                ev.battery_decivolts = (chg_i == 0) ? 10'd0 : 10'($urandom_range(0, chg_i - 1));
            else if (pick < 8)
                ev.battery_decivolts = 10'($urandom_range(chg_i, 1023));
            else if (pick == 8)
                ev.battery_decivolts = chg;
            else
                ev.battery_decivolts = 10'($urandom_range(0, 1023));

            // motor: idle band, forward, backward, exact threshold or anything
            pick = $urandom_range(0, 9);
            if (pick < 4 && thr_i > 0)
                mv = int'($urandom_range(0, 2 * thr_i - 2)) - (thr_i - 1);
            else if (pick < 4 || pick == 9)
                mv = int'($urandom_range(0, 255)) - 128;
            else if (pick < 6)
                mv = int'($urandom_range(thr_i, 127));
            else if (pick < 8)
                mv = -int'($urandom_range(thr_i, 128));
            else
                mv = $urandom_range(0, 1) ? thr_i : -thr_i;
            ev.motor_volts = mv[7:0];

            // wrapping time: short steps, steps right at the timeout,
            // wild jumps and repeats
            pick = $urandom_range(0, 9);
            if (pick < 5)
                delta = $urandom_range(0, tmo / 3);
            else if (pick < 8)
                delta = tmo + $urandom_range(0, 4) - 2;
            else if (pick == 8)
                delta = $urandom();
            else
                delta = '0;
            ms_now = ms_now + delta;
            ev.now_ms        = ms_now;
            ev.epoch_seconds = $urandom();
            send_event(ev);
        end
        wait_drained();
    endtask

    // output side stalls in bursts of random length
    initial begin
        int stall_left;
        int stall_pct;
        int cyc;
        stall_left = 0;
        stall_pct  = 0;
        cyc        = 0;
        out_stall <= 1'b0;
        forever begin
            @(posedge clk);
            cyc++;
            if (cyc % 64 == 0)
                stall_pct = pick_idle_pct();
            if (stall_left > 0) begin
                stall_left--;
                if (stall_left == 0)
                    out_stall <= 1'b0;
            end else if (idle_on && $urandom_range(0, 99) < stall_pct) begin
                out_stall  <= 1'b1;
                stall_left = $urandom_range(1, 14);
            end
        end
    end

    // watchdog: any accepted request, taken result or apb activity counts as progress
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_req   <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        idle_on  = 1'b1;
        gap_pct  = 0;
        sent_cnt = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed walk under reset thresholds: charge 270, motor 12, timeout 60000
        // home, nothing moving, not charging: stop latched at 1000
        send_fields(ACT_VALID, 0, 0, 32'd1000, 32'h0000_0000);
        // exactly at the timeout: still stopped
        send_fields(ACT_VALID, 0, 0, 32'd61000, 32'h0000_0001);
        // one past the timeout: alarm
        send_fields(ACT_VALID, 0, 0, 32'd61001, 32'h0000_0002);
        // full battery, motor idle: back home
        send_fields(ACT_VALID, 1023, 0, 32'd61002, 32'h0000_0003);
        // just below charge, motor at threshold: trip leaves home, latch epoch
        send_fields(ACT_VALID, 269, 12, 32'd61003, 32'hFFFF_FFFF);
        // link drop with every field high
        send_fields(ACT_LINK_TIMEOUT, 1023, -1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // undefined action code acts as a link drop, no change
        send_fields(ACT_UNUSED, 0, 0, 32'h0, 32'h0);
        // charging while moving keeps forward
        send_fields(ACT_VALID, 270, 127, 32'd100, 32'h0000_0010);
        // charging and idle: home
        send_fields(ACT_VALID, 270, 0, 32'd200, 32'h0000_0011);
        // backward at negative threshold, new trip start of zero
        send_fields(ACT_VALID, 0, -12, 32'd300, 32'h0000_0000);
        // most negative motor value
        send_fields(ACT_VALID, 0, -128, 32'd400, 32'h0000_0012);
        // just inside the idle band: stopped, stop latched near the wrap point
        send_fields(ACT_VALID, 0, -11, 32'hFFFF_FFF0, 32'h0000_0013);
        // malformed counts as zero readings; wrapped elapsed equals the timeout
        send_fields(ACT_MALFORMED, 1023, 127, 32'h0000_EA50, 32'h0000_0014);
        // malformed again, wrapped elapsed one past: alarm
        send_fields(ACT_MALFORMED, 1023, 127, 32'h0000_EA51, 32'h0000_0015);
        // alarm to forward does not latch a new trip start
        send_fields(ACT_VALID, 0, 12, 32'h0000_EA52, 32'h1234_5678);
        // malformed from forward: stopped
        send_fields(ACT_MALFORMED, 0, 0, 32'h0000_0100, 32'h0000_0016);
        // stopped to backward, no trip latch
        send_fields(ACT_VALID, 100, -13, 32'h0000_0101, 32'h0000_0017);
        // below both thresholds: stopped
        send_fields(ACT_VALID, 269, 11, 32'h0000_0200, 32'h0000_0018);
        // moving and charging while stopped: only the timeout check applies
        send_fields(ACT_VALID, 300, 50, 32'h0000_0210, 32'h0000_0019);
        // stopped, charging, idle: home
        send_fields(ACT_VALID, 512, 0, 32'h0000_0220, 32'h0000_001A);
        // moving and charging at home: stays home
        send_fields(ACT_VALID, 270, 12, 32'h0000_0230, 32'h0000_001B);
        // link drop with the sign bit of the motor set
        send_fields(ACT_LINK_TIMEOUT, 1023, -128, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // back to a reading: stopped again
        send_fields(ACT_VALID, 0, 0, 32'h0000_0240, 32'h0000_001C);
        wait_drained();

        // random phases across several threshold settings, extremes included
        run_phase(120, CHARGE_THR_RST, MOTOR_THR_RST, STOP_TMO_RST);
        run_phase(130, 10'd0, 7'd0, 32'd0);
        run_phase(130, 10'd1023, 7'd127, 32'hFFFF_FFFF);
        run_phase(140, 10'($urandom_range(1, 1022)), 7'($urandom_range(1, 126)),
                  32'($urandom_range(1, 3000)));
        run_phase(140, 10'($urandom_range(0, 1023)), 7'($urandom_range(0, 127)), $urandom());

        // last part at full rate on both sides
        idle_on = 1'b0;
        run_phase(190, 10'd300, 7'd20, 32'd1500);

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
